@@ hw/rtl/deq_pkg.sv @@
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types, codes and defaults for the double-ended queue unit.
// ----------------------------------------------------------------------------
package deq_pkg;

    // Default sizes of the ring store.
    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    // Fixed widths of the channel fields.
    localparam int CMD_W    = 3;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int OCC_W    = 7;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_POP_BACK   = 3'd3,
        CMD_DISCARD    = 3'd4,
        CMD_CLEAR      = 3'd5
    } cmd_t;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 2'd0,
        STAT_EMPTY     = 2'd1,
        STAT_FULL      = 2'd2,
        STAT_NOT_FOUND = 2'd3
    } status_t;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_POP  = 2'd1,
        S_SCAN = 2'd2
    } state_t;

    // Port enables from the controller to the ring store.
    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } mem_ctl_t;

endpackage

@@ hw/rtl/deq_ram.sv @@
// ----------------------------------------------------------------------------
// deq_ram
// Ring store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    parameter int IW         = $clog2(DEPTH)
) (
    input  logic                  aclk,
    input  deq_pkg::mem_ctl_t     ctl,
    input  logic [IW-1:0]         waddr,
    input  logic [DATA_WIDTH-1:0] wdata,
    input  logic [IW-1:0]         raddr,
    output logic [DATA_WIDTH-1:0] rdata
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    // Write port.
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem[waddr] <= wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge aclk) begin
        if (ctl.rd_en) begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ hw/rtl/deq_ctrl.sv @@
// ----------------------------------------------------------------------------
// deq_ctrl
// Command sequencer: keeps head, tail and count, drives the ring store and
// holds the result register.
// ----------------------------------------------------------------------------
module deq_ctrl #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    parameter int IW         = $clog2(DEPTH),
    parameter int CW         = $clog2(DEPTH + 1)
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [deq_pkg::CMD_W-1:0]           s_cmd,
    input  logic signed [deq_pkg::VALUE_W-1:0]  s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [deq_pkg::VALUE_W-1:0]  m_popped_value,
    output logic [deq_pkg::STATUS_W-1:0]        m_status,
    output logic [deq_pkg::OCC_W-1:0]           m_occupancy,
    output deq_pkg::mem_ctl_t                   mem_ctl,
    output logic [IW-1:0]                       mem_waddr,
    output logic [DATA_WIDTH-1:0]               mem_wdata,
    output logic [IW-1:0]                       mem_raddr,
    input  logic [DATA_WIDTH-1:0]               mem_rdata
);

    localparam logic [IW-1:0] LAST_IDX = IW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    deq_pkg::state_t state_reg, state_next;
    logic [IW-1:0]   head_reg, head_next;
    logic [IW-1:0]   tail_reg, tail_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [IW-1:0]   scan_reg, scan_next;
    logic [CW-1:0]   skip_reg, skip_next;
    logic [DATA_WIDTH-1:0] key_reg, key_next;

    logic                               m_valid_reg, m_valid_next;
    logic [deq_pkg::VALUE_W-1:0]        popped_reg, popped_next;
    deq_pkg::status_t                   status_reg, status_next;
    logic [deq_pkg::OCC_W-1:0]          occ_reg, occ_next;

    logic [DATA_WIDTH-1:0] in_data;
    logic                  is_full;
    logic                  queue_empty;

    function automatic logic [IW-1:0] ring_next(input logic [IW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IW-1:0] ring_prev(input logic [IW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    // Entries keep the low bits of the zero-extended input value.
    assign in_data     = DATA_WIDTH'($unsigned(s_value));
    assign is_full     = (count_reg == FULL_CNT);
    assign queue_empty = (count_reg == '0);

    // Control and pointer registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= deq_pkg::S_IDLE;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Scan state and result payload.
    always_ff @(posedge aclk) begin
        scan_reg   <= scan_next;
        skip_reg   <= skip_next;
        key_reg    <= key_next;
        popped_reg <= popped_next;
        status_reg <= status_next;
        occ_reg    <= occ_next;
    end

    // Next state, store accesses and results.
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        count_next   = count_reg;
        scan_next    = scan_reg;
        skip_next    = skip_reg;
        key_next     = key_reg;
        popped_next  = popped_reg;
        status_next  = status_reg;
        occ_next     = occ_reg;
        m_valid_next = m_valid_reg && !m_ready;
        s_ready      = 1'b0;
        mem_ctl      = '0;
        mem_waddr    = tail_reg;
        mem_wdata    = in_data;
        mem_raddr    = head_reg;

        case (state_reg)
            deq_pkg::S_IDLE: begin
                s_ready = !m_valid_reg || m_ready;
                if (s_valid && s_ready) begin
                    popped_next = '0;
                    status_next = deq_pkg::STAT_OK;
                    key_next    = in_data;
                    case (deq_pkg::cmd_t'(s_cmd))
                        deq_pkg::CMD_PUSH_BACK: begin
                            if (is_full) begin
                                status_next = deq_pkg::STAT_FULL;
                            end else begin
                                mem_ctl.wr_en = 1'b1;
                                mem_waddr     = tail_reg;
                                tail_next     = ring_next(tail_reg);
                                count_next    = count_reg + 1'b1;
                            end
                            occ_next     = deq_pkg::OCC_W'(count_next);
                            m_valid_next = 1'b1;
                        end
                        deq_pkg::CMD_PUSH_FRONT: begin
                            if (is_full) begin
                                status_next = deq_pkg::STAT_FULL;
                            end else begin
                                mem_ctl.wr_en = 1'b1;
                                mem_waddr     = ring_prev(head_reg);
                                head_next     = ring_prev(head_reg);
                                count_next    = count_reg + 1'b1;
                            end
                            occ_next     = deq_pkg::OCC_W'(count_next);
                            m_valid_next = 1'b1;
                        end
                        deq_pkg::CMD_POP_FRONT: begin
                            if (queue_empty) begin
                                status_next  = deq_pkg::STAT_EMPTY;
                                m_valid_next = 1'b1;
                            end else begin
                                mem_ctl.rd_en = 1'b1;
                                mem_raddr     = head_reg;
                                head_next     = ring_next(head_reg);
                                count_next    = count_reg - 1'b1;
                                state_next    = deq_pkg::S_POP;
                            end
                            occ_next = deq_pkg::OCC_W'(count_next);
                        end
                        deq_pkg::CMD_POP_BACK: begin
                            if (queue_empty) begin
                                status_next  = deq_pkg::STAT_EMPTY;
                                m_valid_next = 1'b1;
                            end else begin
                                mem_ctl.rd_en = 1'b1;
                                mem_raddr     = ring_prev(tail_reg);
                                tail_next     = ring_prev(tail_reg);
                                count_next    = count_reg - 1'b1;
                                state_next    = deq_pkg::S_POP;
                            end
                            occ_next = deq_pkg::OCC_W'(count_next);
                        end
                        deq_pkg::CMD_DISCARD: begin
                            if (queue_empty) begin
                                head_next    = tail_reg;
                                status_next  = deq_pkg::STAT_NOT_FOUND;
                                occ_next     = '0;
                                m_valid_next = 1'b1;
                            end else begin
                                // Start the scan at the front entry.
                                mem_ctl.rd_en = 1'b1;
                                mem_raddr     = head_reg;
                                scan_next     = head_reg;
                                skip_next     = '0;
                                state_next    = deq_pkg::S_SCAN;
                            end
                        end
                        deq_pkg::CMD_CLEAR: begin
                            head_next    = '0;
                            tail_next    = '0;
                            count_next   = '0;
                            occ_next     = '0;
                            m_valid_next = 1'b1;
                        end
                        default: begin
                            occ_next     = deq_pkg::OCC_W'(count_reg);
                            m_valid_next = 1'b1;
                        end
                    endcase
                end
            end

            deq_pkg::S_POP: begin
                // Read data arrives in the cycle after the pop was taken.
                popped_next  = deq_pkg::VALUE_W'(mem_rdata);
                m_valid_next = 1'b1;
                state_next   = deq_pkg::S_IDLE;
            end

            deq_pkg::S_SCAN: begin
                // Compare the entry read last cycle while reading the next one.
                if (mem_rdata == key_reg) begin
                    head_next    = scan_reg;
                    count_next   = count_reg - skip_reg;
                    status_next  = deq_pkg::STAT_OK;
                    occ_next     = deq_pkg::OCC_W'(count_next);
                    m_valid_next = 1'b1;
                    state_next   = deq_pkg::S_IDLE;
                end else if (skip_reg + 1'b1 == count_reg) begin
                    head_next    = tail_reg;
                    count_next   = '0;
                    status_next  = deq_pkg::STAT_NOT_FOUND;
                    occ_next     = '0;
                    m_valid_next = 1'b1;
                    state_next   = deq_pkg::S_IDLE;
                end else begin
                    mem_ctl.rd_en = 1'b1;
                    mem_raddr     = ring_next(scan_reg);
                    scan_next     = ring_next(scan_reg);
                    skip_next     = skip_reg + 1'b1;
                end
            end

            default: begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid        = m_valid_reg;
    assign m_popped_value = $signed(popped_reg);
    assign m_status       = status_reg;
    assign m_occupancy    = occ_reg;

endmodule

@@ hw/rtl/double_ended_queue_unit.sv @@
// Push, clear and commands on an empty or full queue give their result in the
// cycle after the transfer; a pop waits in S_POP for its registered store read.
// A discard reads one entry per cycle through the store's read port: a match
// found k entries behind the front ends the scan and drops the entries before it.
// One push per cycle while results are taken; a pop or discard holds s_ready low.
// Reset clears head, tail, count and the result valid; the store is not cleared.
// ----------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue held in a ring store, with push and pop at both
// ends, discard up to a key, and clear.
// ----------------------------------------------------------------------------
module double_ended_queue_unit #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [deq_pkg::CMD_W-1:0]           s_cmd,
    input  logic signed [deq_pkg::VALUE_W-1:0]  s_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [deq_pkg::VALUE_W-1:0]  m_popped_value,
    output logic [deq_pkg::STATUS_W-1:0]        m_status,
    output logic [deq_pkg::OCC_W-1:0]           m_occupancy
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    deq_pkg::mem_ctl_t     mem_ctl;
    logic [IW-1:0]         mem_waddr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [IW-1:0]         mem_raddr;
    logic [DATA_WIDTH-1:0] mem_rdata;

    // Command sequencer and result register.
    deq_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_popped_value (m_popped_value),
        .m_status       (m_status),
        .m_occupancy    (m_occupancy),
        .mem_ctl        (mem_ctl),
        .mem_waddr      (mem_waddr),
        .mem_wdata      (mem_wdata),
        .mem_raddr      (mem_raddr),
        .mem_rdata      (mem_rdata)
    );

    // Ring store.
    deq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IW         (IW)
    ) u_ram (
        .aclk  (aclk),
        .ctl   (mem_ctl),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

endmodule

@@ test/double_ended_queue_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_unit_test
// Self-checking testbench for the double-ended queue unit. Commands are sent
// over the input channel in random bursts while the result channel stalls on
// its own pattern. A behavioral copy of the ring store predicts every result,
// and each result transfer is compared field by field in arrival order.
// ----------------------------------------------------------------------------
module double_ended_queue_unit_test;

    localparam int RING_DEPTH      = deq_pkg::DEPTH_DEF;
    localparam int IDX_W           = $clog2(RING_DEPTH);
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 80;

    // Command codes the block treats as no operation.
    localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_A = 3'd6;
    localparam logic [deq_pkg::CMD_W-1:0] CMD_SPARE_B = 3'd7;

    // Corner values of the data field.
    localparam logic [deq_pkg::VALUE_W-1:0] VAL_MAX_POS  = 32'h7FFF_FFFF;
    localparam logic [deq_pkg::VALUE_W-1:0] VAL_MIN_NEG  = 32'h8000_0000;
    localparam logic [deq_pkg::VALUE_W-1:0] VAL_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [deq_pkg::VALUE_W-1:0] VAL_ZERO     = 32'h0000_0000;

    typedef struct packed {
        logic [deq_pkg::VALUE_W-1:0] popped;
        deq_pkg::status_t            status;
        logic [deq_pkg::OCC_W-1:0]   occupancy;
    } deq_result_t;

    logic                               aclk = 1'b0;
    logic                               aresetn;
    logic                               s_valid;
    logic                               s_ready;
    logic [deq_pkg::CMD_W-1:0]          s_cmd;
    logic signed [deq_pkg::VALUE_W-1:0] s_value;
    logic                               m_valid;
    logic                               m_ready;
    logic signed [deq_pkg::VALUE_W-1:0] m_popped_value;
    logic [deq_pkg::STATUS_W-1:0]       m_status;
    logic [deq_pkg::OCC_W-1:0]          m_occupancy;

    // Behavioral copy of the queue.
    logic [deq_pkg::VALUE_W-1:0] shadow_ring [RING_DEPTH];
    logic [IDX_W-1:0]            shadow_head;
    logic [IDX_W-1:0]            shadow_tail;
    int unsigned                 shadow_count;

    deq_result_t pending_results [$];
    int          error_count;
    int          burst_left;
    bit          hold_off_request;

    double_ended_queue_unit DUT (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_value        (s_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_popped_value (m_popped_value),
        .m_status       (m_status),
        .m_occupancy    (m_occupancy)
    );

    // Free-running clock.
    always #5 aclk = ~aclk;

    // Apply one command to the shadow queue and return the result it gives.
    function automatic deq_result_t apply_deque_command(
            logic [deq_pkg::CMD_W-1:0] cmd, logic [deq_pkg::VALUE_W-1:0] value);
        deq_result_t      res;
        logic [IDX_W-1:0] idx;
        int unsigned      k;
        bit               found;
        res.popped = '0;
        res.status = deq_pkg::STAT_OK;
        case (cmd)
            deq_pkg::CMD_PUSH_BACK: begin
                if (shadow_count >= RING_DEPTH) begin
                    res.status = deq_pkg::STAT_FULL;
                end else begin
                    shadow_ring[shadow_tail] = value;
                    shadow_tail++;
                    shadow_count++;
                end
            end
            deq_pkg::CMD_PUSH_FRONT: begin
                if (shadow_count >= RING_DEPTH) begin
                    res.status = deq_pkg::STAT_FULL;
                end else begin
                    shadow_head--;
                    shadow_ring[shadow_head] = value;
                    shadow_count++;
                end
            end
            deq_pkg::CMD_POP_FRONT: begin
                if (shadow_count == 0) begin
                    res.status = deq_pkg::STAT_EMPTY;
                end else begin
                    res.popped = shadow_ring[shadow_head];
                    shadow_head++;
                    shadow_count--;
                end
            end
            deq_pkg::CMD_POP_BACK: begin
                if (shadow_count == 0) begin
                    res.status = deq_pkg::STAT_EMPTY;
                end else begin
                    shadow_tail--;
                    res.popped = shadow_ring[shadow_tail];
                    shadow_count--;
                end
            end
            deq_pkg::CMD_DISCARD: begin
                // Scan from the front for the first entry equal to the key.
                found = 1'b0;
                idx   = shadow_head;
                for (k = 0; k < shadow_count; k++) begin
                    if (shadow_ring[idx] == value) begin
                        found = 1'b1;
                        break;
                    end
                    idx++;
                end
                if (found) begin
                    shadow_head  = idx;
                    shadow_count = shadow_count - k;
                end else begin
                    shadow_head  = shadow_tail;
                    shadow_count = 0;
                    res.status   = deq_pkg::STAT_NOT_FOUND;
                end
            end
            deq_pkg::CMD_CLEAR: begin
                shadow_head  = '0;
                shadow_tail  = '0;
                shadow_count = 0;
            end
            default: begin
            end
        endcase
        res.occupancy = shadow_count[deq_pkg::OCC_W-1:0];
        return res;
    endfunction

    // Random data: full range, a small pool that makes keys repeat, or a corner.
    function automatic logic [deq_pkg::VALUE_W-1:0] random_value();
        int unsigned pick;
        pick = $urandom_range(0, 3);
        case (pick)
            0, 1: return $urandom;
            2: return $urandom_range(0, 7);
            default: begin
                case ($urandom_range(0, 3))
                    0: return VAL_MAX_POS;
                    1: return VAL_MIN_NEG;
                    2: return VAL_ALL_ONES;
                    default: return VAL_ZERO;
                endcase
            end
        endcase
    endfunction

    // A discard key: mostly a live entry, otherwise any value.
    function automatic logic [deq_pkg::VALUE_W-1:0] discard_key();
        logic [IDX_W-1:0] idx;
        if (shadow_count > 0 && $urandom_range(0, 3) != 0) begin
            idx = shadow_head + IDX_W'($urandom_range(0, shadow_count - 1));
            return shadow_ring[idx];
        end
        return random_value();
    endfunction

    task automatic report_mismatch(input string what,
                                   input logic [deq_pkg::VALUE_W-1:0] got,
                                   input logic [deq_pkg::VALUE_W-1:0] want);
        $display("%0t ERROR %s: got %h, expected %h", $realtime, what, got, want);
        error_count++;
    endtask

    // Offer one command and hold it until the transfer, then predict its result.
    task automatic send_command(input logic [deq_pkg::CMD_W-1:0] cmd,
                                input logic [deq_pkg::VALUE_W-1:0] value);
        if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = $urandom_range(1, 24);
        end
        s_valid <= 1'b1;
        s_cmd   <= cmd;
        s_value <= value;
        do @(posedge aclk); while (s_ready !== 1'b1);
        pending_results.push_back(apply_deque_command(cmd, value));
        burst_left--;
    endtask

    // Empty queue, field extremes, every command and the spare codes.
    task automatic test_directed_corners();
        send_command(deq_pkg::CMD_POP_FRONT, VAL_ZERO);
        send_command(deq_pkg::CMD_POP_BACK, VAL_ALL_ONES);
        send_command(deq_pkg::CMD_DISCARD, VAL_ZERO);
        send_command(deq_pkg::CMD_PUSH_BACK, VAL_MAX_POS);
        send_command(deq_pkg::CMD_PUSH_FRONT, VAL_MIN_NEG);
        send_command(deq_pkg::CMD_PUSH_BACK, VAL_ALL_ONES);
        send_command(deq_pkg::CMD_PUSH_BACK, VAL_ZERO);
        send_command(deq_pkg::CMD_PUSH_FRONT, 32'h5A5A_A5A5);
        send_command(CMD_SPARE_A, VAL_ALL_ONES);
        send_command(CMD_SPARE_B, VAL_ZERO);
        send_command(deq_pkg::CMD_POP_FRONT, VAL_ZERO);
        send_command(deq_pkg::CMD_POP_BACK, VAL_ZERO);
        // Match in the middle keeps the matching entry.
        send_command(deq_pkg::CMD_DISCARD, VAL_MAX_POS);
        send_command(deq_pkg::CMD_DISCARD, VAL_MAX_POS);
        send_command(deq_pkg::CMD_POP_FRONT, VAL_ZERO);
        send_command(deq_pkg::CMD_PUSH_BACK, 32'h1234_5678);
        send_command(deq_pkg::CMD_PUSH_BACK, 32'hCAFE_0001);
        // No match empties the queue.
        send_command(deq_pkg::CMD_DISCARD, 32'hDEAD_BEEF);
        send_command(deq_pkg::CMD_PUSH_FRONT, 32'h0000_0001);
        send_command(deq_pkg::CMD_PUSH_BACK, 32'h0000_0002);
        send_command(deq_pkg::CMD_CLEAR, VAL_ALL_ONES);
        send_command(deq_pkg::CMD_POP_BACK, VAL_ZERO);
        send_command(deq_pkg::CMD_PUSH_FRONT, 32'hA5A5_5A5A);
        send_command(deq_pkg::CMD_POP_BACK, VAL_ZERO);
    endtask

    // Fill to capacity from both ends, overflow, long scan, then pops from both ends.
    task automatic test_fill_to_capacity();
        logic [deq_pkg::VALUE_W-1:0] last_key;
        int                          i;
        send_command(deq_pkg::CMD_CLEAR, VAL_ZERO);
        for (i = 0; i < RING_DEPTH; i++) begin
            last_key = $urandom;
            send_command(i % 2 ? deq_pkg::CMD_PUSH_FRONT : deq_pkg::CMD_PUSH_BACK,
                         last_key);
        end
        send_command(deq_pkg::CMD_PUSH_BACK, $urandom);
        send_command(deq_pkg::CMD_PUSH_FRONT, $urandom);
        // The last push went to the front, so scan for the back entry instead.
        send_command(deq_pkg::CMD_DISCARD, shadow_ring[shadow_tail - 1'b1]);
        send_command(deq_pkg::CMD_PUSH_FRONT, VAL_MIN_NEG);
        for (i = 0; i < 4; i++) begin
            send_command(i % 2 ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT,
                         VAL_ZERO);
        end
    endtask

    // Long receiver stall while commands keep coming, so the input backs up.
    task automatic test_receiver_hold_off();
        int i;
        hold_off_request = 1'b1;
        burst_left       = 60;
        for (i = 0; i < 40; i++) begin
            if (i % 3 == 2) begin
                send_command(deq_pkg::CMD_POP_FRONT, VAL_ZERO);
            end else begin
                send_command(deq_pkg::CMD_PUSH_BACK, random_value());
            end
        end
    endtask

    // Random commands in phases biased toward filling, balance or draining.
    task automatic test_random_commands(input int count);
        int          i;
        int unsigned push_weight;
        int unsigned pick;
        push_weight = 50;
        for (i = 0; i < count; i++) begin
            if (i % 50 == 0) begin
                case ($urandom_range(0, 2))
                    0: push_weight = 85;
                    1: push_weight = 50;
                    default: push_weight = 20;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < push_weight) begin
                send_command($urandom_range(0, 1) ? deq_pkg::CMD_PUSH_FRONT
                                                  : deq_pkg::CMD_PUSH_BACK,
                             random_value());
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    send_command(deq_pkg::CMD_POP_FRONT, random_value());
                end else if (pick < 80) begin
                    send_command(deq_pkg::CMD_POP_BACK, random_value());
                end else if (pick < 94) begin
                    send_command(deq_pkg::CMD_DISCARD, discard_key());
                end else if (pick < 97) begin
                    send_command(deq_pkg::CMD_CLEAR, random_value());
                end else begin
                    send_command($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B,
                                 random_value());
                end
            end
        end
    endtask

    // Result channel: a changing stall pattern, with a long hold-off on request.
    initial begin : result_receiver
        int unsigned hold_left;
        int unsigned cycle_count;
        hold_left   = 0;
        cycle_count = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (hold_off_request) begin
                hold_off_request = 1'b0;
                hold_left        = HOLD_OFF_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case ((cycle_count / 97) % 4)
                    0: m_ready <= 1'b1;
                    1: m_ready <= 1'($urandom_range(0, 1));
                    2: m_ready <= (cycle_count % 4 == 0);
                    default: m_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Compare every result transfer with the oldest prediction.
    always @(posedge aclk) begin : result_checker
        deq_result_t want;
        if (aresetn === 1'b1 && m_valid === 1'b1 && m_ready === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no command outstanding", m_popped_value, '0);
            end else begin
                want = pending_results.pop_front();
                if (m_popped_value !== want.popped) begin
                    report_mismatch("popped_value", m_popped_value, want.popped);
                end
                if (m_status !== want.status) begin
                    report_mismatch("status", deq_pkg::VALUE_W'(m_status),
                                    deq_pkg::VALUE_W'(want.status));
                end
                if (m_occupancy !== want.occupancy) begin
                    report_mismatch("occupancy", deq_pkg::VALUE_W'(m_occupancy),
                                    deq_pkg::VALUE_W'(want.occupancy));
                end
            end
        end
    end

    // Watchdog: end the run when neither channel transfers for too long.
    initial begin : stall_watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_valid === 1'b1 && s_ready === 1'b1) ||
                (m_valid === 1'b1 && m_ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("%0t ERROR no transfer for %0d cycles", $realtime, STALL_LIMIT);
        $display("double_ended_queue_unit verification failed");
        $finish;
    end

    // Test sequence.
    initial begin : test_sequence
        error_count      = 0;
        burst_left       = 0;
        hold_off_request = 1'b0;
        shadow_head      = '0;
        shadow_tail      = '0;
        shadow_count     = 0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_cmd   <= deq_pkg::CMD_PUSH_BACK;
        s_value <= '0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_corners();
        test_fill_to_capacity();
        test_receiver_hold_off();
        test_random_commands(260);

        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0) begin
            $display("double_ended_queue_unit verification clean");
        end else begin
            $display("double_ended_queue_unit verification failed");
        end
        $finish;
    end

endmodule
